### hdl/mtlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtlt_pkg
// Shared types, character codes and helpers of the markup to line text
// converter.
// ----------------------------------------------------------------------------
package mtlt_pkg;

    localparam int BYTE_W     = 8;
    localparam int MAX_OUT    = 5;
    localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);
    localparam int OUT_IDX_W  = $clog2(MAX_OUT);

    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'd39;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h61;
    localparam logic [BYTE_W-1:0] CH_H      = 8'h68;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h70;
    localparam logic [BYTE_W-1:0] CH_1      = 8'h31;
    localparam logic [BYTE_W-1:0] CH_2      = 8'h32;
    localparam logic [BYTE_W-1:0] CH_3      = 8'h33;
    localparam logic [BYTE_W-1:0] CH_6      = 8'h36;

    typedef enum logic [3:0] {
        PH_PLAIN    = 4'd0,
        PH_SKIPWS   = 4'd1,
        PH_NAME     = 4'd2,
        PH_DISPATCH = 4'd3,
        PH_SEEKQ    = 4'd4,
        PH_HREF     = 4'd5,
        PH_SEEKGT   = 4'd6,
        PH_TEXT     = 4'd7,
        PH_CLOSE    = 4'd8
    } phase_t;

    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [OUT_CNT_W-1:0]           count;
    } out_batch_t;

    function automatic logic is_ws(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_quote(input logic [BYTE_W-1:0] b);
        return (b == CH_SQUOTE) || (b == CH_DQUOTE);
    endfunction

endpackage
`default_nettype wire

### hdl/mtlt_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtlt_core
// Parser state and per-byte decode: turns one accepted markup byte into a
// batch of up to five line text bytes and updates the tag tracking state.
// ----------------------------------------------------------------------------
module mtlt_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire logic [mtlt_pkg::BYTE_W-1:0] in_byte,
    output mtlt_pkg::out_batch_t             batch
);
    import mtlt_pkg::*;

    phase_t              phase_reg,  phase_next;
    logic [BYTE_W-1:0]   first_reg,  first_next;
    logic [BYTE_W-1:0]   second_reg, second_next;
    logic [1:0]          len_reg,    len_next;

    logic is_link, is_head, is_para;

    assign is_link = (len_reg == 2'd1) && (first_reg == CH_A);
    assign is_head = (len_reg != 2'd0) && (first_reg == CH_H);
    assign is_para = (len_reg == 2'd1) && (first_reg == CH_P);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PLAIN;
            first_reg  <= '0;
            second_reg <= '0;
            len_reg    <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            len_reg    <= len_next;
        end
    end

    // next state
    always_comb begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        len_next    = len_reg;
        unique case (phase_reg)
            PH_SKIPWS: begin
                if (!is_ws(in_byte)) begin
                    if (in_byte == CH_LT) begin
                        first_next  = '0;
                        second_next = '0;
                        len_next    = '0;
                        phase_next  = PH_NAME;
                    end else begin
                        phase_next = PH_PLAIN;
                    end
                end
            end
            PH_NAME: begin
                if (in_byte == CH_SLASH) begin
                    first_next  = '0;
                    second_next = '0;
                    len_next    = '0;
                    phase_next  = PH_DISPATCH;
                end else if (in_byte == CH_SPACE || in_byte == CH_GT) begin
                    phase_next = PH_DISPATCH;
                end else if (len_reg == 2'd0) begin
                    first_next = in_byte;
                    len_next   = 2'd1;
                end else if (len_reg == 2'd1) begin
                    second_next = in_byte;
                    len_next    = 2'd2;
                end
            end
            PH_DISPATCH: begin
                if (is_link) begin
                    phase_next = is_quote(in_byte) ? PH_HREF : PH_SEEKQ;
                end else if (is_head) begin
                    phase_next = (in_byte == CH_LT) ? PH_CLOSE : PH_TEXT;
                end else if (is_para) begin
                    phase_next = PH_TEXT;
                end else begin
                    phase_next = PH_PLAIN;
                end
            end
            PH_SEEKQ: begin
                if (is_quote(in_byte)) phase_next = PH_HREF;
            end
            PH_HREF: begin
                if (is_quote(in_byte)) phase_next = PH_SEEKGT;
            end
            PH_SEEKGT: begin
                if (in_byte == CH_GT) phase_next = PH_TEXT;
            end
            PH_TEXT: begin
                if (in_byte == CH_LT) phase_next = PH_CLOSE;
            end
            PH_CLOSE: begin
                if (in_byte == CH_GT) phase_next = PH_PLAIN;
            end
            default: begin
                if (in_byte == CH_NL) begin
                    phase_next = PH_SKIPWS;
                end else if (in_byte == CH_LT) begin
                    first_next  = '0;
                    second_next = '0;
                    len_next    = '0;
                    phase_next  = PH_NAME;
                end else begin
                    phase_next = PH_PLAIN;
                end
            end
        endcase
    end

    // output batch
    always_comb begin
        logic [BYTE_W-1:0] level;
        level       = (len_reg == 2'd2) ? second_reg : '0;
        batch.bytes = '0;
        batch.count = '0;
        unique case (phase_reg)
            PH_SKIPWS: begin
                if (!is_ws(in_byte) && in_byte != CH_LT) begin
                    batch.bytes[0] = in_byte;
                    batch.count    = OUT_CNT_W'(1);
                end
            end
            PH_NAME, PH_SEEKQ: begin
                batch.count = '0;
            end
            PH_DISPATCH: begin
                if (is_link) begin
                    batch.bytes[0] = CH_NL;
                    batch.bytes[1] = CH_EQ;
                    batch.bytes[2] = CH_GT;
                    batch.bytes[3] = CH_SPACE;
                    batch.count    = OUT_CNT_W'(4);
                end else if (is_head) begin
                    if (level == CH_1) begin
                        batch.bytes[0] = CH_HASH;
                        batch.bytes[1] = CH_SPACE;
                        batch.count    = OUT_CNT_W'(2);
                    end else if (level == CH_2) begin
                        batch.bytes[0] = CH_HASH;
                        batch.bytes[1] = CH_HASH;
                        batch.bytes[2] = CH_SPACE;
                        batch.count    = OUT_CNT_W'(3);
                    end else if (level >= CH_3 && level <= CH_6) begin
                        batch.bytes[0] = CH_HASH;
                        batch.bytes[1] = CH_HASH;
                        batch.bytes[2] = CH_HASH;
                        batch.bytes[3] = CH_SPACE;
                        batch.count    = OUT_CNT_W'(4);
                    end
                    if (in_byte != CH_LT) begin
                        batch.bytes[batch.count[OUT_IDX_W-1:0]] = in_byte;
                        batch.count = batch.count + OUT_CNT_W'(1);
                    end
                end else if (is_para) begin
                    batch.bytes[0] = in_byte;
                    batch.count    = OUT_CNT_W'(1);
                end
            end
            PH_HREF: begin
                if (!is_quote(in_byte)) begin
                    batch.bytes[0] = in_byte;
                    batch.count    = OUT_CNT_W'(1);
                end
            end
            PH_SEEKGT: begin
                if (in_byte == CH_GT) begin
                    batch.bytes[0] = CH_SPACE;
                    batch.count    = OUT_CNT_W'(1);
                end
            end
            PH_TEXT: begin
                if (in_byte != CH_LT) begin
                    batch.bytes[0] = in_byte;
                    batch.count    = OUT_CNT_W'(1);
                end
            end
            PH_CLOSE: begin
                if (in_byte == CH_GT) begin
                    batch.bytes[0] = CH_NL;
                    batch.count    = OUT_CNT_W'(1);
                end
            end
            default: begin
                if (in_byte != CH_LT) begin
                    batch.bytes[0] = in_byte;
                    batch.count    = OUT_CNT_W'(1);
                end
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/markup_tag_to_line_text_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// markup_tag_to_line_text_converter
// Streams markup bytes in and line text bytes out.
//
// The s_ channel takes one markup byte per request. Each accepted byte is
// decoded in the cycle it is accepted and gives zero to five output bytes,
// held in a result buffer and sent on the m_ channel one byte per cycle
// while m_tready is high; m_tlast marks the final output byte caused by one
// input byte. Bytes that give no output leave nothing on the m_ channel.
// The first output byte of an input byte is registered and valid in the
// cycle after the input is accepted. Throughput: one input byte per cycle
// while each byte gives at most one output byte and m_tready is high; a byte
// giving more output bytes holds the input until the single output byte
// port of the buffer has sent them all. The next input is taken in the same
// cycle that the last buffered byte is taken, so batches follow without gaps.
// Reset (aresetn low at a clock edge) empties the buffer and returns the
// parser to plain text copying. When the receiver stalls, the buffered byte
// holds on m_tdata and s_tready stays low until the buffer drains.
// ----------------------------------------------------------------------------
module markup_tag_to_line_text_converter (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [mtlt_pkg::BYTE_W-1:0] s_tdata,  // [7:0] in_byte
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [mtlt_pkg::BYTE_W-1:0]      m_tdata,  // [7:0] out_byte
    output logic                             m_tlast
);
    import mtlt_pkg::*;

    out_batch_t                        batch;
    logic [MAX_OUT-1:0][BYTE_W-1:0]    bytes_reg;
    logic [OUT_CNT_W-1:0]              rem_reg,  rem_next;
    logic [OUT_IDX_W-1:0]              idx_reg,  idx_next;
    logic                              accept;
    logic                              pop;

    assign m_tvalid = (rem_reg != '0);
    assign m_tlast  = (rem_reg == OUT_CNT_W'(1));
    assign m_tdata  = bytes_reg[idx_reg];
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (rem_reg == '0) || (m_tlast && m_tready);
    assign accept   = s_tvalid && s_tready;

    mtlt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .batch   (batch)
    );

    always_comb begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (accept) begin
            rem_next = batch.count;
            idx_next = '0;
        end else if (pop) begin
            rem_next = rem_reg - OUT_CNT_W'(1);
            idx_next = idx_reg + OUT_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            idx_reg <= '0;
        end else begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            bytes_reg <= batch.bytes;
        end
    end

endmodule
`default_nettype wire
